[rtl/core/qph_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the quadratic-probe hash multimap.
// Used by the controller, the datapath, the top level and the checker.
package qph_pkg;

	// Field widths of the request and result words.
	localparam int KEY_W  = 31;
	localparam int VAL_W  = 32;
	localparam int KIND_W = 3;
	localparam int CNT_W  = 5;

	// Default table geometry.
	localparam int TABLE_SIZE_DEF = 1024;
	localparam int MAX_PROBES_DEF = 31;

	// The match count saturates here.
	localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

	// Request kinds.
	localparam logic [KIND_W-1:0] KIND_INSERT      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SEARCH_PAIR = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SEARCH_KEY  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DELETE_PAIR = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DELETE_KEY  = 3'd4;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_DONE,
		ST_NOT_FOUND,
		ST_DUPLICATE,
		ST_FULL
	} status_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_READ,
		S_EVAL,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    clr_wr;
		logic    load_item;
		logic    mod_step;
		logic    probe_init;
		logic    mem_rd;
		logic    advance;
		logic    count_inc;
		logic    wr_tomb;
		logic    wr_insert;
		logic    out_load;
		status_t out_status;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic              clr_last;
		logic              mod_done;
		logic              probes_left;
		logic              slot_used;
		logic              slot_tomb;
		logic              key_eq;
		logic              val_eq;
		logic              count_nz;
		logic              out_free;
		logic [KIND_W-1:0] kind;
	} sts_t;

endpackage

[rtl/core/qph_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine of the hash multimap: sequences the clearing pass,
// the key reduction, the probe passes and the result hand-off. Uses qph_pkg.
module qph_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output qph_pkg::cmd_t cmd,
	input  qph_pkg::sts_t sts
);

	qph_pkg::state_t  state_q, state_d;
	logic             pass_q, pass_d;
	qph_pkg::status_t stat_q, stat_d;

	logic             kind_pair, kind_key, kind_ok, is_insert;
	logic             live, pair_hit, key_hit, free_hit;
	qph_pkg::status_t hit_status, end_status;

	// Decode of the request kind and of the slot that was just read.
	assign is_insert = (sts.kind == qph_pkg::KIND_INSERT);
	assign kind_pair = is_insert || (sts.kind == qph_pkg::KIND_SEARCH_PAIR) ||
		(sts.kind == qph_pkg::KIND_DELETE_PAIR);
	assign kind_key  = (sts.kind == qph_pkg::KIND_SEARCH_KEY) ||
		(sts.kind == qph_pkg::KIND_DELETE_KEY);
	assign kind_ok   = kind_pair || kind_key;
	assign live      = sts.slot_used && !sts.slot_tomb;
	assign pair_hit  = kind_pair && live && sts.key_eq && sts.val_eq;
	assign key_hit   = kind_key && live && sts.key_eq;
	assign free_hit  = !sts.slot_used || sts.slot_tomb;

	// Status when a pair is found, and when the search pass runs out.
	assign hit_status = is_insert ? qph_pkg::ST_DUPLICATE : qph_pkg::ST_DONE;
	assign end_status = (kind_key && sts.count_nz) ? qph_pkg::ST_DONE
		: qph_pkg::ST_NOT_FOUND;

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qph_pkg::S_CLEAR;
			pass_q  <= 1'b0;
			stat_q  <= qph_pkg::ST_NOT_FOUND;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
			stat_q  <= stat_d;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		pass_d  = pass_q;
		stat_d  = stat_q;
		case (state_q)
			qph_pkg::S_CLEAR: begin
				if (sts.clr_last) state_d = qph_pkg::S_IDLE;
			end
			qph_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = qph_pkg::S_MOD;
					pass_d  = 1'b0;
				end
			end
			qph_pkg::S_MOD: begin
				if (sts.mod_done) begin
					if (kind_ok) begin
						state_d = qph_pkg::S_READ;
					end else begin
						stat_d  = qph_pkg::ST_NOT_FOUND;
						state_d = qph_pkg::S_FINISH;
					end
				end
			end
			qph_pkg::S_READ: begin
				if (sts.probes_left) begin
					state_d = qph_pkg::S_EVAL;
				end else if (pass_q) begin
					stat_d  = qph_pkg::ST_FULL;
					state_d = qph_pkg::S_FINISH;
				end else if (is_insert) begin
					pass_d = 1'b1;
				end else begin
					stat_d  = end_status;
					state_d = qph_pkg::S_FINISH;
				end
			end
			qph_pkg::S_EVAL: begin
				state_d = qph_pkg::S_READ;
				if (pass_q) begin
					if (free_hit) begin
						stat_d  = qph_pkg::ST_DONE;
						state_d = qph_pkg::S_FINISH;
					end
				end else if (!sts.slot_used) begin
					if (is_insert) begin
						pass_d = 1'b1;
					end else begin
						stat_d  = end_status;
						state_d = qph_pkg::S_FINISH;
					end
				end else if (pair_hit) begin
					stat_d  = hit_status;
					state_d = qph_pkg::S_FINISH;
				end
			end
			qph_pkg::S_FINISH: begin
				if (sts.out_free) state_d = qph_pkg::S_IDLE;
			end
			default: begin
				state_d = qph_pkg::S_CLEAR;
			end
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd            = '0;
		cmd.out_status = stat_q;
		in_stall       = 1'b1;
		case (state_q)
			qph_pkg::S_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			qph_pkg::S_IDLE: begin
				in_stall      = 1'b0;
				cmd.load_item = in_valid;
			end
			qph_pkg::S_MOD: begin
				if (sts.mod_done) cmd.probe_init = kind_ok;
				else cmd.mod_step = 1'b1;
			end
			qph_pkg::S_READ: begin
				if (sts.probes_left) cmd.mem_rd = 1'b1;
				else if (!pass_q && is_insert) cmd.probe_init = 1'b1;
			end
			qph_pkg::S_EVAL: begin
				if (pass_q) begin
					if (free_hit) cmd.wr_insert = 1'b1;
					else cmd.advance = 1'b1;
				end else if (!sts.slot_used) begin
					cmd.probe_init = is_insert;
				end else if (pair_hit) begin
					cmd.wr_tomb = (sts.kind == qph_pkg::KIND_DELETE_PAIR);
				end else begin
					cmd.advance = 1'b1;
					if (key_hit) begin
						cmd.count_inc = 1'b1;
						cmd.wr_tomb   = (sts.kind == qph_pkg::KIND_DELETE_KEY);
					end
				end
			end
			qph_pkg::S_FINISH: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[rtl/core/qph_dpath.sv]
`timescale 1ns / 1ps
// Datapath of the hash multimap: request registers, key reduction, probe
// address generator, slot memories and the result register. Uses qph_pkg.
module qph_dpath #(
	parameter int TABLE_SIZE = qph_pkg::TABLE_SIZE_DEF,
	parameter int MAX_PROBES = qph_pkg::MAX_PROBES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  qph_pkg::cmd_t                cmd,
	output qph_pkg::sts_t                sts,
	input  logic [qph_pkg::KIND_W-1:0]   kind,
	input  logic [qph_pkg::KEY_W-1:0]    key,
	input  logic signed [qph_pkg::VAL_W-1:0] value,
	input  logic                         last_of_batch,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [qph_pkg::CNT_W-1:0]    match_count,
	output logic                         batch_done
);

	localparam int AW   = $clog2(TABLE_SIZE);
	localparam int PW   = $clog2(MAX_PROBES + 1);
	localparam int KVW  = qph_pkg::KEY_W + qph_pkg::VAL_W;
	localparam bit POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
	localparam logic [AW:0]     TSZ      = (AW + 1)'(TABLE_SIZE);
	localparam logic [AW-1:0]   CLR_LAST = AW'(TABLE_SIZE - 1);
	localparam logic [PW-1:0]   PROBES   = PW'(MAX_PROBES);
	// Slot flags are {used, tombstone}.
	localparam logic [1:0] META_EMPTY = 2'b00;
	localparam logic [1:0] META_LIVE  = 2'b10;
	localparam logic [1:0] META_TOMB  = 2'b11;

	logic [qph_pkg::KIND_W-1:0] kind_q;
	logic [qph_pkg::KEY_W-1:0]  key_q;
	logic [qph_pkg::VAL_W-1:0]  value_q;
	logic                       last_q;
	logic [AW-1:0]              slot_q, step_q, clr_q, rem;
	logic [PW-1:0]              probe_q;
	logic [qph_pkg::CNT_W-1:0]  count_q;
	logic [AW:0]                slot_sum, slot_nx, step_sum, step_nx;
	logic                       mod_done;

	logic [1:0]     meta_mem [TABLE_SIZE];
	logic [KVW-1:0] kv_mem [TABLE_SIZE];
	logic [1:0]     meta_rd_q;
	logic [KVW-1:0] kv_rd_q;
	logic           meta_we;
	logic [AW-1:0]  meta_wa;
	logic [1:0]     meta_wd;

	logic                      out_valid_q, out_free, batch_q;
	logic [1:0]                status_q;
	logic [qph_pkg::CNT_W-1:0] match_q;

	// Request registers and the saturating match counter.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q  <= kind;
			key_q   <= key;
			value_q <= value;
			last_q  <= last_of_batch;
			count_q <= '0;
		end else if (cmd.count_inc && (count_q != qph_pkg::COUNT_MAX)) begin
			count_q <= count_q + 1'b1;
		end
	end

	// Home slot: key modulo the table size.
	generate
		if (POW2) begin : g_pow2
			assign rem      = key_q[AW-1:0];
			assign mod_done = 1'b1;
		end else begin : g_recip
			localparam int KW  = qph_pkg::KEY_W;
			localparam int RW  = KW + 1;
			localparam int PRW = KW + RW;
			localparam int QW  = PRW - KW - AW;
			localparam logic [1:0] MOD_STEPS = 2'd2;
			// Rounded-up reciprocal; exact for every key below 2^KW.
			localparam logic [RW-1:0] RECIP = RW'(((64'd1 << (KW + AW)) +
				64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));

			logic [1:0]     mcnt_q;
			logic [PRW-1:0] prod_q;
			logic [QW-1:0]  quot;
			logic [KW-1:0]  qmul;
			logic [AW-1:0]  rem_q;

			// Quotient from the reciprocal product, then back to the remainder.
			assign quot = prod_q[PRW-1 -: QW];
			assign qmul = KW'(quot) * KW'(TABLE_SIZE);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					mcnt_q <= '0;
				end else if (cmd.load_item) begin
					mcnt_q <= MOD_STEPS;
				end else if (cmd.mod_step) begin
					mcnt_q <= mcnt_q - 1'b1;
				end
			end

			// First step multiplies, second step subtracts.
			always_ff @(posedge clk) begin
				if (cmd.mod_step) begin
					if (mcnt_q == MOD_STEPS) prod_q <= PRW'(key_q) * PRW'(RECIP);
					else rem_q <= AW'(key_q - qmul);
				end
			end

			assign rem      = rem_q;
			assign mod_done = (mcnt_q == '0);
		end
	endgenerate

	// Probe address generator: the slot moves by 2i+1 each probe, both mod size.
	assign slot_sum = {1'b0, slot_q} + {1'b0, step_q};
	assign slot_nx  = (slot_sum >= TSZ) ? (slot_sum - TSZ) : slot_sum;
	assign step_sum = {1'b0, step_q} + (AW + 1)'(2);
	assign step_nx  = (step_sum >= TSZ) ? (step_sum - TSZ) : step_sum;

	always_ff @(posedge clk) begin
		if (cmd.probe_init) begin
			slot_q  <= rem;
			step_q  <= AW'(1);
			probe_q <= '0;
		end else if (cmd.advance) begin
			slot_q  <= slot_nx[AW-1:0];
			step_q  <= step_nx[AW-1:0];
			probe_q <= probe_q + 1'b1;
		end
	end

	// Address counter of the clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr_wr) clr_q <= clr_q + 1'b1;
	end

	// Slot flag memory write port.
	assign meta_we = cmd.clr_wr || cmd.wr_tomb || cmd.wr_insert;
	assign meta_wa = cmd.clr_wr ? clr_q : slot_q;
	assign meta_wd = cmd.clr_wr ? META_EMPTY : (cmd.wr_insert ? META_LIVE : META_TOMB);

	// Slot memories with registered reads.
	always_ff @(posedge clk) begin
		if (meta_we) meta_mem[meta_wa] <= meta_wd;
		if (cmd.mem_rd) meta_rd_q <= meta_mem[slot_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_insert) kv_mem[slot_q] <= {key_q, value_q};
		if (cmd.mem_rd) kv_rd_q <= kv_mem[slot_q];
	end

	// Result register; a waiting word is replaced only once it is taken.
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q <= cmd.out_status;
			match_q  <= count_q;
			batch_q  <= last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign match_count = match_q;
	assign batch_done  = batch_q;

	// Status toward the controller.
	always_comb begin
		sts.clr_last    = (clr_q == CLR_LAST);
		sts.mod_done    = mod_done;
		sts.probes_left = (probe_q < PROBES);
		sts.slot_used   = meta_rd_q[1];
		sts.slot_tomb   = meta_rd_q[0];
		sts.key_eq      = (kv_rd_q[qph_pkg::VAL_W +: qph_pkg::KEY_W] == key_q);
		sts.val_eq      = (kv_rd_q[qph_pkg::VAL_W-1:0] == value_q);
		sts.count_nz    = (count_q != '0);
		sts.out_free    = out_free;
		sts.kind        = kind_q;
	end

endmodule

[rtl/core/quadratic_probe_hash_multimap_top.sv]
`timescale 1ns / 1ps
// Top level of the quadratic-probe hash multimap: controller plus datapath.
// Depends on qph_pkg, qph_ctrl and qph_dpath.

// The block takes one request word at a time and returns one result word for
// each. After reset it first clears the used and tombstone flags of all
// TABLE_SIZE slots, one slot per cycle, and accepts nothing until that
// clearing pass is done. A request is then accepted, its home slot is formed
// (directly when TABLE_SIZE is a power of two, otherwise by a reciprocal
// multiplication and a subtraction), and each probe is one registered read of
// the slot memories followed by an evaluate step. A search or delete probes
// at most MAX_PROBES slots; an insert that finds no duplicate runs a second
// pass for a free slot. The result word is held in an output register; a new
// request is accepted while it waits.
module quadratic_probe_hash_multimap_top #(
	parameter int TABLE_SIZE = qph_pkg::TABLE_SIZE_DEF,
	parameter int MAX_PROBES = qph_pkg::MAX_PROBES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [qph_pkg::KIND_W-1:0]       kind,
	input  logic [qph_pkg::KEY_W-1:0]        key,
	input  logic signed [qph_pkg::VAL_W-1:0] value,
	input  logic                             last_of_batch,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       status,
	output logic [qph_pkg::CNT_W-1:0]        match_count,
	output logic                             batch_done
);

	qph_pkg::cmd_t cmd;
	qph_pkg::sts_t sts;

	// Sequencer.
	qph_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Storage and arithmetic.
	qph_dpath #(
		.TABLE_SIZE (TABLE_SIZE),
		.MAX_PROBES (MAX_PROBES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.kind          (kind),
		.key           (key),
		.value         (value),
		.last_of_batch (last_of_batch),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.match_count   (match_count),
		.batch_done    (batch_done)
	);

endmodule

[rtl/core/qph_chk.sv]
`timescale 1ns / 1ps
// Port-level checker for the hash multimap, bound to the top level.
// Depends on qph_pkg and quadratic_probe_hash_multimap_top.
module qph_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [1:0]                    status,
	input logic [qph_pkg::CNT_W-1:0]     match_count,
	input logic                          batch_done
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(match_count) && $stable(batch_done))
		else $error("result word changed while stalled");

	// The block works on one request at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted on consecutive cycles");

	// A nonzero count comes only with a successful result.
	a_count_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (match_count != '0) |-> status == qph_pkg::ST_DONE)
		else $error("match count without success status");

	// Insert outcomes carry no count.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == qph_pkg::ST_DUPLICATE || status == qph_pkg::ST_FULL)
		|-> match_count == '0)
		else $error("count on a duplicate or full result");

endmodule

bind quadratic_probe_hash_multimap_top qph_chk u_qph_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.match_count (match_count),
	.batch_done  (batch_done)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for quadratic_probe_hash_multimap_top: a directed table of
// requests, then random request streams, each result checked against a shadow table.
// Depends on qph_pkg and the top level of the hash multimap.
module tb_top;
	import qph_pkg::*;

	localparam int TBL = TABLE_SIZE_DEF;
	localparam int PROBES = MAX_PROBES_DEF;
	localparam int RANDOM_ITEMS = 500;
	localparam int TAIL_ITEMS = 60;
	localparam int MID_DRAIN_AT = 250;
	localparam int SETTLE_CYCLES = 300;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [KEY_W-1:0] KEY_TOP = {KEY_W{1'b1}};
	localparam logic [VAL_W-1:0] VAL_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] VAL_NEG_MAX = 32'h8000_0000;
	localparam logic [VAL_W-1:0] VAL_ALL_ONES = 32'hFFFF_FFFF;

	// Kind codes the block does not define; it must leave the table alone.
	localparam logic [KIND_W-1:0] KIND_RSVD_A = 3'd5;
	localparam logic [KIND_W-1:0] KIND_RSVD_B = 3'd6;
	localparam logic [KIND_W-1:0] KIND_RSVD_C = 3'd7;

	typedef struct packed {
		status_t          st;
		logic [CNT_W-1:0] cnt;
		logic             batch;
	} result_word_t;

	typedef struct {
		logic [KIND_W-1:0] op;
		logic [KEY_W-1:0]  req_key;
		logic [VAL_W-1:0]  req_val;
		logic              last;
		bit                fixed;
		status_t           st;
		logic [CNT_W-1:0]  cnt;
	} request_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [KIND_W-1:0]        kind = '0;
	logic [KEY_W-1:0]         key = '0;
	logic signed [VAL_W-1:0]  value = '0;
	logic                     last_of_batch = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [1:0]               status;
	logic [CNT_W-1:0]         match_count;
	logic                     batch_done;

	// Typed-in expectation that travels with a directed word.
	logic                     row_fixed = 1'b0;
	status_t                  row_status = ST_DONE;
	logic [CNT_W-1:0]         row_count = '0;

	// Shadow copy of the slot table; used and tombstone flags start cleared.
	logic [KEY_W-1:0]         shadow_key [TBL];
	logic [VAL_W-1:0]         shadow_val [TBL];
	bit                       shadow_used [TBL];
	bit                       shadow_tomb [TBL];

	result_word_t             pending_results [$];
	request_row_t             directed_rows [$];
	int                       error_count = 0;
	int                       cycle_count = 0;
	bit                       tail_phase = 1'b0;
	bit                       send_calm = 1'b0;

	quadratic_probe_hash_multimap_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.key           (key),
		.value         (value),
		.last_of_batch (last_of_batch),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.match_count   (match_count),
		.batch_done    (batch_done)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top failed");
		$finish;
	end

	task automatic flag_error(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic int probe_slot_of(input logic [KEY_W-1:0] k, input int i);
		logic [31:0] sum;
		sum = {1'b0, k} + 32'(i * i);
		return int'(sum % TBL);
	endfunction

	// Slot of the first live copy of the pair, or -1; the walk stops at a never-used slot.
	function automatic int find_live_pair(input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
		int s;
		for (int i = 0; i < PROBES; i++) begin
			s = probe_slot_of(k, i);
			if (!shadow_used[s])
				return -1;
			if (!shadow_tomb[s] && shadow_key[s] == k && shadow_val[s] == v)
				return s;
		end
		return -1;
	endfunction

	// Applies one request to the shadow table and returns the status and count it gives.
	task automatic apply_request(input logic [KIND_W-1:0] op, input logic [KEY_W-1:0] k,
		input logic [VAL_W-1:0] v, output status_t st, output logic [CNT_W-1:0] cnt);
		int s;
		int hit;
		st = ST_NOT_FOUND;
		cnt = '0;
		case (op)
			KIND_INSERT: begin
				if (find_live_pair(k, v) >= 0) begin
					st = ST_DUPLICATE;
				end else begin
					st = ST_FULL;
					for (int i = 0; i < PROBES; i++) begin
						s = probe_slot_of(k, i);
						if (!shadow_used[s] || shadow_tomb[s]) begin
							shadow_key[s] = k;
							shadow_val[s] = v;
							shadow_used[s] = 1'b1;
							shadow_tomb[s] = 1'b0;
							st = ST_DONE;
							break;
						end
					end
				end
			end
			KIND_SEARCH_PAIR: begin
				st = (find_live_pair(k, v) >= 0) ? ST_DONE : ST_NOT_FOUND;
			end
			KIND_SEARCH_KEY, KIND_DELETE_KEY: begin
				for (int i = 0; i < PROBES; i++) begin
					s = probe_slot_of(k, i);
					if (!shadow_used[s])
						break;
					if (!shadow_tomb[s] && shadow_key[s] == k) begin
						if (op == KIND_DELETE_KEY)
							shadow_tomb[s] = 1'b1;
						if (cnt < COUNT_MAX)
							cnt++;
					end
				end
				st = (cnt != 0) ? ST_DONE : ST_NOT_FOUND;
			end
			KIND_DELETE_PAIR: begin
				hit = find_live_pair(k, v);
				if (hit >= 0) begin
					shadow_tomb[hit] = 1'b1;
					st = ST_DONE;
				end
			end
			default: begin
			end
		endcase
	endtask

	// Result words are checked before request words are predicted, so a result
	// leaving at the same edge always belongs to an older request.
	always @(posedge clk) begin : scoreboard
		status_t          st;
		logic [CNT_W-1:0] cnt;
		result_word_t     want;
		if (out_valid === 1'b1 && !out_stall) begin
			if (pending_results.size() == 0) begin
				flag_error($sformatf("result word with none pending: status %0d count %0d",
					status, match_count));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st)
					flag_error($sformatf("status %0d, wanted %0d", status, want.st));
				if (match_count !== want.cnt)
					flag_error($sformatf("match_count %0d, wanted %0d", match_count, want.cnt));
				if (batch_done !== want.batch)
					flag_error($sformatf("batch_done %0b, wanted %0b", batch_done, want.batch));
			end
		end
		if (in_valid && in_stall === 1'b0) begin
			apply_request(kind, key, value, st, cnt);
			if (row_fixed) begin
				st = row_status;
				cnt = row_count;
			end
			want.st = st;
			want.cnt = cnt;
			want.batch = last_of_batch;
			pending_results.push_back(want);
		end
	end

	function automatic request_row_t make_row(input logic [KIND_W-1:0] op,
		input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v, input logic last,
		input bit fixed = 1'b0, input status_t st = ST_DONE, input logic [CNT_W-1:0] cnt = '0);
		request_row_t r;
		r.op = op;
		r.req_key = k;
		r.req_val = v;
		r.last = last;
		r.fixed = fixed;
		r.st = st;
		r.cnt = cnt;
		return r;
	endfunction

	// Offers one request word, with a random gap first unless the sender is calm or in the tail phase.
	task automatic send_request(input request_row_t r);
		if (!tail_phase && !send_calm && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		kind <= r.op;
		key <= r.req_key;
		value <= r.req_val;
		last_of_batch <= r.last;
		row_fixed <= r.fixed;
		row_status <= r.st;
		row_count <= r.cnt;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
	endtask

	// Holds the sender off until every pending result word has come back.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// Receiver stalls: busy stretches with random bursts, calm stretches and the tail phase with none.
	initial begin : receiver
		bit calm;
		forever begin
			calm = ($urandom_range(0, 2) == 0);
			repeat ($urandom_range(50, 400)) begin
				@(posedge clk);
				if (!calm && !tail_phase && $urandom_range(0, 3) == 0) begin
					out_stall <= 1'b1;
					repeat ($urandom_range(1, 14)) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	initial begin : stimulus
		logic [KEY_W-1:0]  key_pool [12];
		logic [VAL_W-1:0]  val_pool [4];
		int                home [3];
		logic [KEY_W-1:0]  k;
		logic [VAL_W-1:0]  v;
		logic [KIND_W-1:0] op;
		int                pick;
		int                sent;
		int                fills;
		bit                mid_drained;

		// Directed table: empty-table misses, extremes of key and value, duplicates,
		// tombstones, reuse of a tombstoned slot and the undefined kinds.
		directed_rows.push_back(make_row(KIND_SEARCH_KEY, '0, '0, 1'b0, 1'b1, ST_NOT_FOUND));
		directed_rows.push_back(make_row(KIND_SEARCH_PAIR, KEY_TOP, VAL_POS_MAX, 1'b0,
			1'b1, ST_NOT_FOUND));
		directed_rows.push_back(make_row(KIND_DELETE_KEY, 31'd12345, '0, 1'b1, 1'b1,
			ST_NOT_FOUND));
		directed_rows.push_back(make_row(KIND_DELETE_PAIR, '0, '0, 1'b0, 1'b1, ST_NOT_FOUND));
		directed_rows.push_back(make_row(KIND_INSERT, '0, '0, 1'b0, 1'b1, ST_DONE));
		directed_rows.push_back(make_row(KIND_INSERT, '0, '0, 1'b0, 1'b1, ST_DUPLICATE));
		directed_rows.push_back(make_row(KIND_INSERT, KEY_TOP, VAL_POS_MAX, 1'b0, 1'b1, ST_DONE));
		directed_rows.push_back(make_row(KIND_INSERT, KEY_TOP, VAL_NEG_MAX, 1'b0));
		directed_rows.push_back(make_row(KIND_INSERT, '0, VAL_ALL_ONES, 1'b1));
		directed_rows.push_back(make_row(KIND_SEARCH_PAIR, '0, '0, 1'b0));
		directed_rows.push_back(make_row(KIND_SEARCH_KEY, KEY_TOP, VAL_ALL_ONES, 1'b0));
		directed_rows.push_back(make_row(KIND_SEARCH_PAIR, '0, 32'd1, 1'b0));
		directed_rows.push_back(make_row(KIND_DELETE_PAIR, '0, '0, 1'b0));
		directed_rows.push_back(make_row(KIND_SEARCH_PAIR, '0, '0, 1'b1));
		directed_rows.push_back(make_row(KIND_SEARCH_KEY, '0, '0, 1'b0));
		directed_rows.push_back(make_row(KIND_INSERT, '0, '0, 1'b0));
		directed_rows.push_back(make_row(KIND_DELETE_KEY, KEY_TOP, '0, 1'b0));
		directed_rows.push_back(make_row(KIND_DELETE_KEY, KEY_TOP, '0, 1'b0, 1'b1,
			ST_NOT_FOUND));
		directed_rows.push_back(make_row(KIND_RSVD_A, '0, '0, 1'b0, 1'b1, ST_NOT_FOUND));
		directed_rows.push_back(make_row(KIND_RSVD_B, KEY_TOP, VAL_ALL_ONES, 1'b1, 1'b1,
			ST_NOT_FOUND));
		directed_rows.push_back(make_row(KIND_RSVD_C, 31'd7, VAL_NEG_MAX, 1'b0, 1'b1,
			ST_NOT_FOUND));
		directed_rows.push_back(make_row(KIND_SEARCH_KEY, 31'(TBL), '0, 1'b0));
		directed_rows.push_back(make_row(KIND_INSERT, 31'(TBL), 32'h5555_5555, 1'b0));
		directed_rows.push_back(make_row(KIND_DELETE_KEY, '0, '0, 1'b1));
		directed_rows.push_back(make_row(KIND_SEARCH_PAIR, 31'(TBL), 32'hAAAA_AAAA, 1'b0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i]);
		wait_for_drain();

		// Key pool on three home slots, two of them adjacent, so probe paths cross.
		home[0] = $urandom_range(0, TBL - 1);
		home[1] = (home[0] + 1) % TBL;
		home[2] = $urandom_range(0, TBL - 1);
		foreach (key_pool[i]) begin
			k = KEY_W'($urandom());
			key_pool[i] = k - KEY_W'(k % TBL) + KEY_W'(home[i % 3]);
		end
		foreach (val_pool[i])
			val_pool[i] = $urandom();

		sent = 0;
		fills = 0;
		mid_drained = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= RANDOM_ITEMS - TAIL_ITEMS)
				tail_phase = 1'b1;
			if ($urandom_range(0, 39) == 0)
				send_calm = ($urandom_range(0, 3) == 0);
			if (!mid_drained && sent >= MID_DRAIN_AT) begin
				wait_for_drain();
				mid_drained = 1'b1;
			end

			if (fills < 3 && !tail_phase &&
				($urandom_range(0, 29) == 0 || sent > 140 * (fills + 1))) begin
				// Fill one probe path with a single key by PROBES + 2 inserts, so that the last
				// ones report no free slot, then count it (the count may reach its ceiling) and remove it.
				k = ($urandom_range(0, 1) == 0) ? key_pool[$urandom_range(0, 11)] :
					KEY_W'($urandom());
				v = $urandom();
				for (int j = 0; j < PROBES + 2; j++) begin
					send_request(make_row(KIND_INSERT, k, v + VAL_W'(j),
						1'($urandom_range(0, 1))));
					sent++;
				end
				send_request(make_row(KIND_SEARCH_KEY, k, $urandom(), 1'b0));
				send_request(make_row(KIND_DELETE_KEY, k, $urandom(), 1'b0));
				send_request(make_row(KIND_SEARCH_KEY, k, $urandom(), 1'b1));
				sent += 3;
				fills++;
			end else begin
				k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 11)] :
					KEY_W'($urandom());
				v = ($urandom_range(0, 99) < 75) ? val_pool[$urandom_range(0, 3)] : $urandom();
				pick = $urandom_range(0, 99);
				if (pick < 35)
					op = KIND_INSERT;
				else if (pick < 50)
					op = KIND_SEARCH_PAIR;
				else if (pick < 65)
					op = KIND_SEARCH_KEY;
				else if (pick < 80)
					op = KIND_DELETE_PAIR;
				else if (pick < 94)
					op = KIND_DELETE_KEY;
				else begin
					case ($urandom_range(0, 2))
						0: op = KIND_RSVD_A;
						1: op = KIND_RSVD_B;
						default: op = KIND_RSVD_C;
					endcase
				end
				send_request(make_row(op, k, v, 1'($urandom_range(0, 1))));
				// Undefined kinds leave the table alone and do not count toward the total.
				if (op <= KIND_DELETE_KEY)
					sent++;
			end
		end

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
